// ----- rtl/vn_pkg.sv -----
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the vector normalizer
// Component widths, lane widths of the digit cells and the beat structs.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int COMP_WIDTH  = 16;
  localparam int UNIT_FRAC   = 14;
  localparam int UNIT_STEPS  = UNIT_FRAC + 1;
  localparam int OUT_WIDTH   = 16;
  localparam int SQ_W        = 2 * COMP_WIDTH;
  localparam int ROOT_REM_W  = 2 * COMP_WIDTH + 2;
  localparam int UNIT_REM_W  = 2 * COMP_WIDTH + 2 * UNIT_FRAC + 3;
  localparam int CHAIN_LEN   = (COMP_WIDTH > UNIT_STEPS) ? COMP_WIDTH : UNIT_STEPS;
  localparam int LEN_EXT_W   = (COMP_WIDTH > OUT_WIDTH) ? COMP_WIDTH : OUT_WIDTH;
  localparam logic [OUT_WIDTH-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] in_x;
    logic signed [COMP_WIDTH-1:0] in_y;
    logic signed [COMP_WIDTH-1:0] in_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic signed [OUT_WIDTH-1:0] unit_z;
    logic        [OUT_WIDTH-1:0] vec_length;
  } vn_out_t;

  // Squared terms handed from the front end to the cell row.
  typedef struct packed {
    logic [SQ_W-1:0]        sq_sum;
    logic [2:0][SQ_W-1:0]   comp_sq;
    logic [2:0]             neg;
  } vn_sq_t;

endpackage

// ----- rtl/vn_front.sv -----
// ----------------------------------------------------------------------------
// vn_front: magnitude, square and sum stages
// Three registered stages that turn a signed vector into squared terms.
// ----------------------------------------------------------------------------
module vn_front import vn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  vn_in_t data_i,
  output logic   valid_o,
  output vn_sq_t data_o
);

  logic [2:0]                  vld_q;
  logic [2:0][COMP_WIDTH-1:0]  mag_q;
  logic [2:0]                  neg1_q, neg2_q;
  logic [2:0][SQ_W-1:0]        sq_q;
  vn_sq_t                      out_q;
  logic [2:0][COMP_WIDTH-1:0]  comp;

  assign comp = {data_i.in_x, data_i.in_y, data_i.in_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        neg1_q[c] <= comp[c][COMP_WIDTH-1];
        mag_q[c]  <= comp[c][COMP_WIDTH-1] ? (~comp[c] + 1'b1) : comp[c];
        sq_q[c]   <= SQ_W'(mag_q[c]) * SQ_W'(mag_q[c]);
      end
      neg2_q        <= neg1_q;
      out_q.comp_sq <= sq_q;
      out_q.neg     <= neg2_q;
      out_q.sq_sum  <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = out_q;

endmodule

// ----- rtl/vn_digit_cell.sv -----
// ----------------------------------------------------------------------------
// vn_digit_cell: one digit of a restoring root or quotient extraction
// Tries bit K of the result and keeps it when the remainder allows.
// ----------------------------------------------------------------------------
module vn_digit_cell import vn_pkg::*; #(
  parameter int RW = ROOT_REM_W,
  parameter int QW = COMP_WIDTH,
  parameter int K  = 0,
  parameter bit EN = 1'b1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] step_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] acc_i,
  input  logic [QW-1:0] quo_i,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] acc_o,
  output logic [QW-1:0] quo_o
);

  logic [RW-1:0] rem_d, acc_d, rem_q, acc_q;
  logic [QW-1:0] quo_d, quo_q;

  if (EN) begin : g_step
    // Keeping the bit adds (2*acc*2^K + step*4^K) to the square, with acc
    // being the running product of the partial result and the step.
    logic [RW:0] delta;
    assign delta = ({1'b0, acc_i} << (K + 1)) + ({1'b0, step_i} << (2 * K));
    always_comb begin
      if (delta <= {1'b0, rem_i}) begin
        rem_d = rem_i - delta[RW-1:0];
        acc_d = acc_i + (step_i << K);
        quo_d = quo_i | (QW'(1) << K);
      end else begin
        rem_d = rem_i;
        acc_d = acc_i;
        quo_d = quo_i;
      end
    end
  end else begin : g_pass
    assign rem_d = rem_i;
    assign acc_d = acc_i;
    assign quo_d = quo_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign acc_o = acc_q;
  assign quo_o = quo_q;

endmodule

// ----- rtl/vector3_normalize.sv -----
// ----------------------------------------------------------------------------
// vector3_normalize: fixed-point 3D vector normalizer
// Length and unit vector of one signed Q8.8 vector per beat.
// ----------------------------------------------------------------------------
// The block takes one vector beat per clock while not stalled and returns
// one result beat per vector, in order. Three front stages form the
// magnitudes, squares and their sum; a row of CHAIN_LEN digit stages then
// extracts one bit of the square root per stage, and one bit of each unit
// component in each of the first UNIT_STEPS stages; the last stage feeds the
// output directly. The whole pipeline freezes while a result beat is stalled,
// and stall_o is raised only in that case, so a new vector is taken every
// cycle the output side keeps up. A zero vector yields zero length and a zero
// unit vector. Length is the floor of the square root in Q8.8; unit
// components are Q1.14 truncated toward zero, computed against the exact
// root rather than the truncated length.
module vector3_normalize import vn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  vn_in_t  in_data_i,
  output logic    stall_o,
  output logic    out_valid_o,
  output vn_out_t out_data_o,
  input  logic    stall_i
);

  logic   adv;
  logic   fr_valid;
  vn_sq_t fr_data;

  // Index 0 holds the row inputs, index j+1 the registers of stage j.
  logic [CHAIN_LEN:0]                  vld;
  logic [CHAIN_LEN:0][SQ_W-1:0]        sum;
  logic [CHAIN_LEN:0][2:0]             neg;
  logic [CHAIN_LEN:0][ROOT_REM_W-1:0]  r_rem, r_acc;
  logic [CHAIN_LEN:0][COMP_WIDTH-1:0]  r_quo;
  logic [CHAIN_LEN:0][2:0][UNIT_REM_W-1:0] u_rem, u_acc;
  logic [CHAIN_LEN:0][2:0][UNIT_STEPS-1:0] u_quo;

  logic [CHAIN_LEN-1:0] vld_q;
  logic [CHAIN_LEN-1:0][SQ_W-1:0] sum_q;
  logic [CHAIN_LEN-1:0][2:0]      neg_q;

  // Freeze everything while the finished beat waits.
  assign adv     = !(vld[CHAIN_LEN] && stall_i);
  assign stall_o = !adv;

  vn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  assign vld[0]   = fr_valid;
  assign sum[0]   = fr_data.sq_sum;
  assign neg[0]   = fr_data.neg;
  assign r_rem[0] = ROOT_REM_W'(fr_data.sq_sum);
  assign r_acc[0] = '0;
  assign r_quo[0] = '0;
  for (genvar c = 0; c < 3; c++) begin : g_init
    assign u_rem[0][c] = UNIT_REM_W'(fr_data.comp_sq[c]) << (2 * UNIT_FRAC);
    assign u_acc[0][c] = '0;
    assign u_quo[0][c] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld[CHAIN_LEN-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sum[CHAIN_LEN-1:0];
      neg_q <= neg[CHAIN_LEN-1:0];
    end
  end

  for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_row
    localparam bit RootEn = (j < COMP_WIDTH);
    localparam bit UnitEn = (j < UNIT_STEPS);
    localparam int RootK  = RootEn ? (COMP_WIDTH - 1 - j) : 0;
    localparam int UnitK  = UnitEn ? (UNIT_FRAC - j) : 0;

    assign vld[j+1] = vld_q[j];
    assign sum[j+1] = sum_q[j];
    assign neg[j+1] = neg_q[j];

    // Square root lane: the step is one, so acc tracks the partial root.
    vn_digit_cell #(
      .RW (ROOT_REM_W), .QW (COMP_WIDTH), .K (RootK), .EN (RootEn)
    ) u_root (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (ROOT_REM_W'(1)),
      .rem_i  (r_rem[j]),
      .acc_i  (r_acc[j]),
      .quo_i  (r_quo[j]),
      .rem_o  (r_rem[j+1]),
      .acc_o  (r_acc[j+1]),
      .quo_o  (r_quo[j+1])
    );

    // Unit lanes: largest u with u^2 * s <= c^2 * 2^28.
    for (genvar c = 0; c < 3; c++) begin : g_lane
      vn_digit_cell #(
        .RW (UNIT_REM_W), .QW (UNIT_STEPS), .K (UnitK), .EN (UnitEn)
      ) u_unit (
        .clk_i  (clk_i),
        .en_i   (adv),
        .step_i (UNIT_REM_W'(sum[j])),
        .rem_i  (u_rem[j][c]),
        .acc_i  (u_acc[j][c]),
        .quo_i  (u_quo[j][c]),
        .rem_o  (u_rem[j+1][c]),
        .acc_o  (u_acc[j+1][c]),
        .quo_o  (u_quo[j+1][c])
      );
    end
  end

  // Result assembly from the last stage.
  logic                        is_zero;
  logic [LEN_EXT_W-1:0]        root_ext;
  logic [2:0][OUT_WIDTH-1:0]   unit_val;

  assign is_zero  = (sum[CHAIN_LEN] == '0);
  assign root_ext = LEN_EXT_W'(r_quo[CHAIN_LEN]);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (is_zero) begin
        unit_val[c] = '0;
      end else if (neg[CHAIN_LEN][c]) begin
        unit_val[c] = OUT_WIDTH'(~OUT_WIDTH'(u_quo[CHAIN_LEN][c]) + 1'b1);
      end else begin
        unit_val[c] = OUT_WIDTH'(u_quo[CHAIN_LEN][c]);
      end
    end
  end

  assign out_valid_o           = vld[CHAIN_LEN];
  assign out_data_o.unit_x     = unit_val[2];
  assign out_data_o.unit_y     = unit_val[1];
  assign out_data_o.unit_z     = unit_val[0];
  assign out_data_o.vec_length = (root_ext > LEN_EXT_W'(LEN_MAX)) ? LEN_MAX
                                                                  : root_ext[OUT_WIDTH-1:0];

endmodule

// ----- rtl/vn_checker.sv -----
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the vector normalizer
// Watches the handshakes and result ranges on the top level's ports.
// ----------------------------------------------------------------------------
module vn_checker import vn_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input vn_in_t  in_data_i,
  input logic    stall_o,
  input logic    out_valid_o,
  input vn_out_t out_data_o,
  input logic    stall_i
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The input side is held back only behind a waiting result beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> out_valid_o && stall_i)
    else $error("input stalled without a stalled result");

  // Unit components never exceed one in magnitude.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.unit_x <= 16'sd16384 && out_data_o.unit_x >= -16'sd16384 &&
      out_data_o.unit_y <= 16'sd16384 && out_data_o.unit_y >= -16'sd16384 &&
      out_data_o.unit_z <= 16'sd16384 && out_data_o.unit_z >= -16'sd16384)
    else $error("unit component out of range");

  // Zero length occurs only for the zero vector.
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.vec_length == '0 |->
      out_data_o.unit_x == '0 && out_data_o.unit_y == '0 &&
      out_data_o.unit_z == '0)
    else $error("zero length with nonzero unit vector");

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_data_i);

endmodule

bind vector3_normalize vn_checker u_vn_checker (.*);
